// ----- src/gaa_pkg.sv -----
// ============================================================================
// gaa_pkg: shared types and constants for the gravity acceleration block
// Controller states, datapath commands and status, and register defaults.
// ============================================================================
package gaa_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned StepW  = 5;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [WordW-1:0] GravConstRst = 32'd6554;
    localparam logic [WordW-1:0] MinDistSqRst = 32'd655360;
    localparam logic [WordW-1:0] MaxDistSqRst = 32'd65536000;

    localparam logic [CfgIdxW-1:0] CfgGravConst = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMinDistSq = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxDistSq = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_GM,
        ST_DINIT_M,
        ST_DSTEP_M,
        ST_MX,
        ST_DINIT_X,
        ST_DSTEP_X,
        ST_MY,
        ST_DINIT_Y,
        ST_DSTEP_Y,
        ST_ACC
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AXX,
        MUL_AYY,
        MUL_GM,
        MUL_AXM,
        MUL_AYM
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_MAG,
        DIV_X,
        DIV_Y
    } div_src_t;

    typedef struct packed {
        logic     load;
        mul_op_t  mul_op;
        logic     sum_sq;
        logic     clamp;
        logic     div_init;
        div_src_t div_src;
        logic     sqrt_init;
        logic     step;
        logic     save_mag;
        logic     save_px;
        logic     acc;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic out_stall;
    } stat_t;

endpackage

// ----- src/gaa_ctrl.sv -----
// ============================================================================
// gaa_ctrl: sequencer for one item
// Steps the shared multiplier, divider and square root unit through the work
// of one item and counts the iterations of the divider.
// ============================================================================
module gaa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  gaa_pkg::stat_t st,
    output gaa_pkg::cmd_t  cmd
);

    gaa_pkg::state_t               state_reg, state_next;
    logic [gaa_pkg::StepW-1:0]     cnt_reg, cnt_next;
    logic                          last;

    assign last = (cnt_reg == {gaa_pkg::StepW{1'b1}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gaa_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            gaa_pkg::ST_IDLE:    if (s_tvalid) state_next = gaa_pkg::ST_SQX;
            gaa_pkg::ST_SQX:     state_next = st.zero ? gaa_pkg::ST_ACC : gaa_pkg::ST_SQY;
            gaa_pkg::ST_SQY:     state_next = gaa_pkg::ST_SUM;
            gaa_pkg::ST_SUM:     state_next = gaa_pkg::ST_GM;
            gaa_pkg::ST_GM:      state_next = gaa_pkg::ST_DINIT_M;
            gaa_pkg::ST_DINIT_M: begin
                state_next = gaa_pkg::ST_DSTEP_M;
                cnt_next   = '0;
            end
            gaa_pkg::ST_DSTEP_M: begin
                cnt_next = cnt_reg + 1'b1;
                if (last) state_next = gaa_pkg::ST_MX;
            end
            gaa_pkg::ST_MX:      state_next = gaa_pkg::ST_DINIT_X;
            gaa_pkg::ST_DINIT_X: begin
                state_next = gaa_pkg::ST_DSTEP_X;
                cnt_next   = '0;
            end
            gaa_pkg::ST_DSTEP_X: begin
                cnt_next = cnt_reg + 1'b1;
                if (last) state_next = gaa_pkg::ST_MY;
            end
            gaa_pkg::ST_MY:      state_next = gaa_pkg::ST_DINIT_Y;
            gaa_pkg::ST_DINIT_Y: begin
                state_next = gaa_pkg::ST_DSTEP_Y;
                cnt_next   = '0;
            end
            gaa_pkg::ST_DSTEP_Y: begin
                cnt_next = cnt_reg + 1'b1;
                if (last) state_next = gaa_pkg::ST_ACC;
            end
            gaa_pkg::ST_ACC:     if (!st.out_stall) state_next = gaa_pkg::ST_IDLE;
            default:             state_next = gaa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.mul_op  = gaa_pkg::MUL_NONE;
        cmd.div_src = gaa_pkg::DIV_MAG;
        s_tready  = 1'b0;
        unique case (state_reg)
            gaa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            gaa_pkg::ST_SQX:     cmd.mul_op = gaa_pkg::MUL_AXX;
            gaa_pkg::ST_SQY:     cmd.mul_op = gaa_pkg::MUL_AYY;
            gaa_pkg::ST_SUM:     cmd.sum_sq = 1'b1;
            gaa_pkg::ST_GM: begin
                cmd.mul_op = gaa_pkg::MUL_GM;
                cmd.clamp  = 1'b1;
            end
            gaa_pkg::ST_DINIT_M: begin
                cmd.div_init  = 1'b1;
                cmd.div_src   = gaa_pkg::DIV_MAG;
                cmd.sqrt_init = 1'b1;
            end
            gaa_pkg::ST_DSTEP_M: begin
                cmd.step    = 1'b1;
                cmd.div_src = gaa_pkg::DIV_MAG;
            end
            gaa_pkg::ST_DSTEP_X: begin
                cmd.step    = 1'b1;
                cmd.div_src = gaa_pkg::DIV_X;
            end
            gaa_pkg::ST_DSTEP_Y: begin
                cmd.step    = 1'b1;
                cmd.div_src = gaa_pkg::DIV_Y;
            end
            gaa_pkg::ST_MX: begin
                cmd.mul_op   = gaa_pkg::MUL_AXM;
                cmd.save_mag = 1'b1;
            end
            gaa_pkg::ST_DINIT_X: begin
                cmd.div_init = 1'b1;
                cmd.div_src  = gaa_pkg::DIV_X;
            end
            gaa_pkg::ST_MY: begin
                cmd.mul_op  = gaa_pkg::MUL_AYM;
                cmd.save_px = 1'b1;
            end
            gaa_pkg::ST_DINIT_Y: begin
                cmd.div_init = 1'b1;
                cmd.div_src  = gaa_pkg::DIV_Y;
            end
            gaa_pkg::ST_ACC:     cmd.acc = !st.out_stall;
            default:             cmd = '0;
        endcase
    end

endmodule

// ----- src/gaa_datapath.sv -----
// ============================================================================
// gaa_datapath: arithmetic for the gravity acceleration block
// Holds the configuration, one shared multiplier, a radix-2 divider, a
// two-bits-per-step square root, the running sums and the output register.
// ============================================================================
module gaa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gaa_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [gaa_pkg::WordW-1:0]     cfg_data,
    input  logic [159:0]                  s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,
    output logic                          m_tuser,
    input  gaa_pkg::cmd_t                 cmd,
    output gaa_pkg::stat_t                st
);

    logic [31:0] grav_reg, min_reg, max_reg;
    logic [31:0] mass_reg;
    logic [30:0] ax_reg, ay_reg;
    logic        negx_reg, negy_reg, zero_reg, sh_reg, clr_reg;
    logic [63:0] prod_reg;
    logic [62:0] s_reg;
    logic [31:0] c_reg, mag_reg, px_reg;
    logic [31:0] drem_reg, dlow_reg, dvs_reg;
    logic        ovf_reg;
    logic [63:0] qsrc_reg;
    logic [34:0] qrem_reg;
    logic [31:0] root_reg;
    logic signed [31:0] sumx_reg, sumy_reg;
    logic        mvalid_reg, msat_reg;
    logic [63:0] mdata_reg;

    logic signed [32:0] dx, dy;
    logic [32:0] abx, aby;
    logic        sh;
    logic [31:0] ma, mb;
    logic [31:0] div_res;
    logic [46:0] s_hi;
    logic [31:0] dsq, clo, chi;
    logic [32:0] dtry;
    logic [34:0] qtry, qtrial;
    logic signed [33:0] addx, addy, basex, basey;
    logic signed [34:0] tx, ty;
    logic signed [31:0] nx, ny;
    logic        clipx, clipy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= gaa_pkg::GravConstRst;
            min_reg  <= gaa_pkg::MinDistSqRst;
            max_reg  <= gaa_pkg::MaxDistSqRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gaa_pkg::CfgGravConst: grav_reg <= cfg_data;
                gaa_pkg::CfgMinDistSq: min_reg  <= cfg_data;
                gaa_pkg::CfgMaxDistSq: max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dx  = $signed({s_tdata[95], s_tdata[95:64]}) - $signed({s_tdata[31], s_tdata[31:0]});
    assign dy  = $signed({s_tdata[127], s_tdata[127:96]}) - $signed({s_tdata[63], s_tdata[63:32]});
    assign abx = dx[32] ? 33'(-dx) : 33'(dx);
    assign aby = dy[32] ? 33'(-dy) : 33'(dy);
    assign sh  = abx[31] | aby[31];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg   <= sh ? abx[31:1] : abx[30:0];
            ay_reg   <= sh ? aby[31:1] : aby[30:0];
            negx_reg <= dx[32];
            negy_reg <= dy[32];
            zero_reg <= (dx == '0) && (dy == '0);
            sh_reg   <= sh;
            clr_reg  <= s_tuser;
            mass_reg <= s_tdata[159:128];
        end
    end

    assign div_res = ovf_reg ? 32'hFFFF_FFFF : dlow_reg;

    always_comb begin
        unique case (cmd.mul_op)
            gaa_pkg::MUL_AXX: begin ma = {1'b0, ax_reg}; mb = {1'b0, ax_reg}; end
            gaa_pkg::MUL_AYY: begin ma = {1'b0, ay_reg}; mb = {1'b0, ay_reg}; end
            gaa_pkg::MUL_GM:  begin ma = grav_reg;       mb = mass_reg;       end
            gaa_pkg::MUL_AXM: begin ma = {1'b0, ax_reg}; mb = div_res;        end
            gaa_pkg::MUL_AYM: begin ma = {1'b0, ay_reg}; mb = mag_reg;        end
            default:          begin ma = '0;             mb = '0;             end
        endcase
    end

    assign s_hi = s_reg[62:16];
    assign dsq  = (sh_reg || (s_hi[46:32] != '0)) ? 32'hFFFF_FFFF : s_hi[31:0];
    assign clo  = (dsq < min_reg) ? min_reg : dsq;
    assign chi  = (clo > max_reg) ? max_reg : clo;

    always_ff @(posedge aclk) begin
        if (cmd.mul_op != gaa_pkg::MUL_NONE) prod_reg <= ma * mb;
        if (cmd.mul_op == gaa_pkg::MUL_AYY) s_reg <= prod_reg[62:0];
        if (cmd.sum_sq) s_reg <= s_reg + prod_reg[62:0];
        if (cmd.clamp) c_reg <= chi;
        if (cmd.save_mag) mag_reg <= div_res;
        if (cmd.save_px) px_reg <= dlow_reg;
    end

    assign dtry = {drem_reg, dlow_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dvs_reg  <= (cmd.div_src == gaa_pkg::DIV_MAG) ? c_reg : root_reg;
            drem_reg <= prod_reg[63:32];
            dlow_reg <= prod_reg[31:0];
            ovf_reg  <= (cmd.div_src == gaa_pkg::DIV_MAG) && (prod_reg[63:32] >= c_reg);
        end else if (cmd.step) begin
            if (!dtry[32]) begin
                drem_reg <= dtry[31:0];
                dlow_reg <= {dlow_reg[30:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[30:0], dlow_reg[31]};
                dlow_reg <= {dlow_reg[30:0], 1'b0};
            end
        end
    end

    assign qtry   = {qrem_reg[32:0], qsrc_reg[63:62]};
    assign qtrial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            qsrc_reg <= {1'b0, s_reg};
            qrem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.step && (cmd.div_src == gaa_pkg::DIV_MAG) && !cmd.div_init) begin
            qsrc_reg <= {qsrc_reg[61:0], 2'b00};
            if (qtry >= qtrial) begin
                qrem_reg <= qtry - qtrial;
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                qrem_reg <= qtry;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign addx  = zero_reg ? '0 : (negx_reg ? -$signed({2'b00, px_reg}) : $signed({2'b00, px_reg}));
    assign addy  = zero_reg ? '0 : (negy_reg ? -$signed({2'b00, dlow_reg}) : $signed({2'b00, dlow_reg}));
    assign basex = clr_reg ? '0 : 34'(sumx_reg);
    assign basey = clr_reg ? '0 : 34'(sumy_reg);
    assign tx    = 35'(basex) + 35'(addx);
    assign ty    = 35'(basey) + 35'(addy);
    assign clipx = (tx > 35'sd2147483647) || (tx < -35'sd2147483648);
    assign clipy = (ty > 35'sd2147483647) || (ty < -35'sd2147483648);
    assign nx    = (tx > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                   (tx < -35'sd2147483648) ? 32'sh8000_0000 : tx[31:0];
    assign ny    = (ty > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                   (ty < -35'sd2147483648) ? 32'sh8000_0000 : ty[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else if (cmd.acc) begin
            sumx_reg   <= nx;
            sumy_reg   <= ny;
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            mdata_reg <= {ny, nx};
            msat_reg  <= clipx | clipy;
        end
    end

    assign m_tvalid     = mvalid_reg;
    assign m_tdata      = mdata_reg;
    assign m_tuser      = msat_reg;
    assign st.zero      = zero_reg;
    assign st.out_stall = mvalid_reg && !m_tready;

endmodule

// ----- src/gravity_accel_accumulate.sv -----
// ============================================================================
// gravity_accel_accumulate: clamped gravity pull, accumulated per particle
// Adds one body's gravitational acceleration to a running Q16.16 sum.
// ============================================================================
// Usage:
// The input item carries the particle and body positions and the body mass on
// s_tdata and a clear flag on s_tuser. The result item carries the two sums on
// m_tdata and the saturation flag on m_tuser. Configuration registers are
// written through cfg_wr_en, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. An
// item with a nonzero offset goes from acceptance to the result register
// through three multiplies, then 32 divider steps that run alongside the 32
// square root steps, then two more multiply and 32-step divide rounds. The
// radix-2 divider is shared by the three quotients. A zero offset skips to
// the result. A new item is accepted in the cycle after the previous result
// is written. Reset restores the default constants, clears both sums and
// empties the output register. When the receiver stalls, a finished result
// waits in the output register; the next item is still accepted and computed,
// and it holds at the final step until the output register is free.
module gravity_accel_accumulate (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gaa_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [gaa_pkg::WordW-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // self_x, self_y, other_x, other_y, other_mass
    input  logic [159:0]                  s_tdata,
    // clear_first
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // acc_x, acc_y
    output logic [63:0]                   m_tdata,
    // saturated
    output logic                          m_tuser
);

    gaa_pkg::cmd_t  cmd;
    gaa_pkg::stat_t st;

    gaa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gaa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ----- src/gaa_checker.sv -----
// ============================================================================
// gaa_port_checks: port-level checks for the gravity acceleration block
// Watches the handshakes and reset behavior seen at the top level.
// ============================================================================
module gaa_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item was in progress");

    a_out_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_result_without_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared while idle");

endmodule

bind gravity_accel_accumulate gaa_port_checks u_gaa_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
